>>> rtl/slm_pkg.sv
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types, constants and a helper function of the stereo LED level meter.
// ----------------------------------------------------------------------------
package slm_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int MAX_PAIRS_DEF   = 1023;

  localparam int LED_TOTAL  = 8;
  localparam int TABLE_LEDS = 8;
  localparam int MASK_W     = 8;

  localparam int SUM_W     = 34;
  localparam int LEVEL_W   = 26;
  localparam int GAIN_W    = 16;
  localparam int WIN_W     = 10;
  localparam int FRAC_W    = 12;
  localparam int PROD_W    = SUM_W + GAIN_W;
  localparam int STEP_W    = PROD_W - FRAC_W;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int DIV_STEPS = SUM_W;
  localparam int MUL_STEPS = GAIN_W;
  localparam int ITER_W    = $clog2(DIV_STEPS);

  localparam logic [WIN_W-1:0]  WINDOW_LEN_RST   = WIN_W'(60);
  localparam logic [GAIN_W-1:0] ATTACK_GAIN_RST  = GAIN_W'(14336);
  localparam logic [GAIN_W-1:0] RELEASE_GAIN_RST = GAIN_W'(328);
  localparam logic [PROD_W-1:0] ROUND_HALF       = PROD_W'(2048);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX       = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEN   = 2'd0,
    REG_ATTACK_GAIN  = 2'd1,
    REG_RELEASE_GAIN = 2'd2
  } cfg_reg_t;

  // LED thresholds in Q.23, lowest LED first.
  localparam logic [LEVEL_W-1:0] LED_THRESHOLD [TABLE_LEDS] = '{
    LEVEL_W'(6664),   LEVEL_W'(13296),  LEVEL_W'(26528),  LEVEL_W'(52929),
    LEVEL_W'(105607), LEVEL_W'(210713), LEVEL_W'(420427), LEVEL_W'(600745)
  };

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_PREP  = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_APPLY = 6'b010000,
    ST_EMIT  = 6'b100000
  } slm_state_t;

  typedef struct packed {
    logic accept;
    logic div_load;
    logic div_step;
    logic prep;
    logic mul_step;
    logic apply;
    logic emit;
  } slm_cmd_t;

  typedef struct packed {
    logic upd_hit;
    logic out_free;
  } slm_status_t;

  function automatic logic [MASK_W-1:0] led_mask_of(input logic [LEVEL_W-1:0] level);
    logic [MASK_W-1:0] m;
    int b;
    m = '0;
    for (int i = 0; i < TABLE_LEDS; i++) begin
      b = LED_TOTAL - 1 - i;
      if (i < LED_TOTAL && b >= 0 && b < MASK_W && level >= LED_THRESHOLD[i]) begin
        m[b] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

>>> rtl/slm_if.sv
// ----------------------------------------------------------------------------
// slm_in_if / slm_out_if
// Valid/ready channels of the level meter: sample pairs in, meter words out.
// ----------------------------------------------------------------------------
interface slm_in_if import slm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic                          frame_last;

  modport source (output valid, left_sample, right_sample, frame_last, input ready);
  modport sink   (input valid, left_sample, right_sample, frame_last, output ready);
endinterface

interface slm_out_if import slm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MASK_W-1:0]  led_mask;
  logic [LEVEL_W-1:0] smoothed_level;

  modport source (output valid, led_mask, smoothed_level, input ready);
  modport sink   (input valid, led_mask, smoothed_level, output ready);
endinterface

>>> rtl/stereo_led_level_meter_core.sv
// Stereo LED level meter. Each accepted word is one stereo pair; |left|+|right|
// goes into a saturating sum and the pair count goes up. A word that closes a
// frame with at least window_len pairs pending starts an update: a radix-2
// divider forms the mean, a shift-add multiplier forms the attack or release
// step, and the smoothed level with its LED mask is placed in the output
// register. Ordinary words are taken while idle; an update holds the input
// off until its word is emitted, including any wait for the output register
// to free up. Configuration is written through cfg_we/cfg_index/cfg_data; the
// user must write it only while the meter is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
// stereo_led_level_meter_core
// Top level of the level meter: sequencer and datapath on two valid/ready
// channels and a configuration write port.
// ----------------------------------------------------------------------------
module stereo_led_level_meter_core import slm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_PAIRS   = MAX_PAIRS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  slm_in_if.sink               sample_in,
  slm_out_if.source            level_out
);

  slm_cmd_t    cmd;
  slm_status_t status;
  logic        in_ready;

  assign sample_in.ready = in_ready;

  slm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  slm_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_PAIRS   (MAX_PAIRS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_left   (sample_in.left_sample),
    .in_right  (sample_in.right_sample),
    .in_last   (sample_in.frame_last),
    .out_ready (level_out.ready),
    .out_valid (level_out.valid),
    .out_mask  (level_out.led_mask),
    .out_level (level_out.smoothed_level),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

>>> rtl/slm_ctrl.sv
// ----------------------------------------------------------------------------
// slm_ctrl
// Sequencer of the level meter: accumulate, divide, multiply, apply, emit.
// ----------------------------------------------------------------------------
module slm_ctrl import slm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  slm_status_t status,
  output slm_cmd_t    cmd
);

  slm_state_t          state, state_next;
  logic [ITER_W-1:0]   iter, iter_next;

  always_comb begin
    state_next = state;
    iter_next  = iter;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.accept   = in_valid;
        cmd.div_load = in_valid && status.upd_hit;
        if (in_valid && status.upd_hit) begin
          state_next = ST_DIV;
          iter_next  = '0;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        iter_next    = iter + 1'b1;
        if (iter == ITER_W'(DIV_STEPS - 1)) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        iter_next  = '0;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        iter_next    = iter + 1'b1;
        if (iter == ITER_W'(MUL_STEPS - 1)) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold here until the output register can take the new word.
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
    end
  end

endmodule

>>> rtl/slm_dp.sv
// ----------------------------------------------------------------------------
// slm_dp
// Datapath of the level meter: configuration registers, saturating sum and
// count, radix-2 divider, shift-add multiplier, smoothing and output register.
// ----------------------------------------------------------------------------
module slm_dp import slm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_PAIRS   = MAX_PAIRS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic [SAMPLE_BITS-1:0] in_left,
  input  logic [SAMPLE_BITS-1:0] in_right,
  input  logic                   in_last,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [MASK_W-1:0]      out_mask,
  output logic [LEVEL_W-1:0]     out_level,
  input  slm_cmd_t               cmd,
  output slm_status_t            status
);

  localparam int CNT_W = $clog2(MAX_PAIRS + 1);
  localparam int DVS_W = CNT_W + 1;
  localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;

  logic [WIN_W-1:0]   window_len;
  logic [GAIN_W-1:0]  attack_gain;
  logic [GAIN_W-1:0]  release_gain;
  logic [SUM_W-1:0]   level_sum;
  logic [CNT_W-1:0]   pair_count;
  logic [LEVEL_W-1:0] smoothed;

  logic [SUM_W-1:0]   dvd;
  logic [DVS_W-1:0]   dvs;
  logic [DVS_W-1:0]   rem;
  logic [PROD_W-1:0]  acc;
  logic [PROD_W-1:0]  mcand;
  logic [GAIN_W-1:0]  gsh;
  logic               rise;

  logic [SAMPLE_BITS-1:0] mag_l, mag_r;
  logic [SAMPLE_BITS:0]   pair_add;
  logic [SUM_W:0]         sum_wide;
  logic [SUM_W-1:0]       sum_new;
  logic [CNT_W-1:0]       cnt_new;
  logic [WIN_W-1:0]       win_eff;
  logic [DVS_W:0]         rem_sh;
  logic                   rem_ge;
  logic [SUM_W-1:0]       sm_ext;
  logic                   rising;
  logic [SUM_W-1:0]       diff;
  logic [STEP_W-1:0]      step;
  logic [STEP_W:0]        up_sum;
  logic [LEVEL_W-1:0]     smoothed_next;

  // The most negative sample inverts to itself, which read unsigned is 2^(N-1).
  assign mag_l    = in_left[SAMPLE_BITS-1]  ? (~in_left + 1'b1)  : in_left;
  assign mag_r    = in_right[SAMPLE_BITS-1] ? (~in_right + 1'b1) : in_right;
  assign pair_add = {1'b0, mag_l} + {1'b0, mag_r};
  assign sum_wide = {1'b0, level_sum} + (SUM_W + 1)'(pair_add);
  assign sum_new  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
  assign cnt_new  = (pair_count == CNT_W'(MAX_PAIRS)) ? pair_count : pair_count + 1'b1;
  assign win_eff  = (window_len == '0) ? WIN_W'(1) : window_len;

  assign status.upd_hit  = in_last && (CMP_W'(cnt_new) >= CMP_W'(win_eff));
  assign status.out_free = !out_valid || out_ready;

  assign rem_sh = {rem, dvd[SUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, dvs};

  assign sm_ext = SUM_W'(smoothed);
  assign rising = dvd > sm_ext;
  assign diff   = rising ? (dvd - sm_ext) : (sm_ext - dvd);

  // The accumulator starts at one half LSB of the result, so this is the rounded step.
  assign step   = acc[PROD_W-1:FRAC_W];
  assign up_sum = {1'b0, step} + (STEP_W + 1)'(smoothed);

  always_comb begin
    if (rise) begin
      smoothed_next = (up_sum > (STEP_W + 1)'(LEVEL_MAX)) ? LEVEL_MAX : up_sum[LEVEL_W-1:0];
    end else begin
      smoothed_next = (step >= STEP_W'(smoothed)) ? '0 : smoothed - step[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len   <= WINDOW_LEN_RST;
      attack_gain  <= ATTACK_GAIN_RST;
      release_gain <= RELEASE_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WINDOW_LEN:   window_len   <= cfg_data[WIN_W-1:0];
        REG_ATTACK_GAIN:  attack_gain  <= cfg_data[GAIN_W-1:0];
        REG_RELEASE_GAIN: release_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_sum  <= '0;
      pair_count <= '0;
      smoothed   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.div_load) begin
        level_sum  <= '0;
        pair_count <= '0;
      end else if (cmd.accept) begin
        level_sum  <= sum_new;
        pair_count <= cnt_new;
      end
      if (cmd.apply) begin
        smoothed <= smoothed_next;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Divider and multiplier registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd <= sum_new;
      dvs <= {cnt_new, 1'b0};
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_ge ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
      dvd <= {dvd[SUM_W-2:0], rem_ge};
    end
    if (cmd.prep) begin
      mcand <= PROD_W'(diff);
      gsh   <= rising ? attack_gain : release_gain;
      acc   <= ROUND_HALF;
      rise  <= rising;
    end else if (cmd.mul_step) begin
      if (gsh[0]) begin
        acc <= acc + mcand;
      end
      mcand <= {mcand[PROD_W-2:0], 1'b0};
      gsh   <= {1'b0, gsh[GAIN_W-1:1]};
    end
    if (cmd.emit) begin
      out_mask  <= led_mask_of(smoothed);
      out_level <= smoothed;
    end
  end

endmodule
